>>> design/dhcp_client_engine_defines.svh
// Assertion macros shared by the client engine.
`ifndef DHCP_CLIENT_ENGINE_DEFINES_SVH
`define DHCP_CLIENT_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define DCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DCE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DCE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/dce_pkg.sv
package dce_pkg;

  localparam int FRAME_WORDS = 38;
  localparam int FW_W = $clog2(FRAME_WORDS + 1);

  localparam logic [1:0] ST_INIT       = 2'd0;
  localparam logic [1:0] ST_SELECTING  = 2'd1;
  localparam logic [1:0] ST_REQUESTING = 2'd2;
  localparam logic [1:0] ST_BOUND      = 2'd3;

  localparam logic [7:0] MSG_DISCOVER = 8'd1;
  localparam logic [7:0] MSG_OFFER    = 8'd2;
  localparam logic [7:0] MSG_REQUEST  = 8'd3;
  localparam logic [7:0] MSG_ACK      = 8'd5;

  localparam logic [31:0] COOKIE_WORD = 32'h6353_8263;
  localparam logic [31:0] RANDOM_SEED = 32'h34aa_d34b;
  localparam logic [7:0]  WAIT_RESET  = 8'd100;

  localparam logic CFG_MAC     = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic        command;
    logic        enable;
    logic [63:0] rx_data;
    logic        rx_last;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [63:0] tx_data;
    logic [7:0]  tx_keep;
    logic        tx_last;
    logic [31:0] ip_address;
    logic        is_bound;
  } out_item_t;

  // One job handed from the front to the back: either a frame or a single status item.
  typedef struct packed {
    logic        send;
    logic        request;
    logic [31:0] ident;
    logic [31:0] req_ip;
    logic [47:0] mac;
    logic [31:0] bound_ip;
    logic        is_bound;
  } job_t;

  function automatic logic [63:0] frame_word(input logic [FW_W-1:0] k, input job_t j);
    logic [63:0] w;
    w = '0;
    case (k)
      FW_W'(0): w = {j.ident, 8'h00, 8'h06, 8'h01, 8'h01};
      FW_W'(1): w = 64'h0000_0000_0080_0000;
      FW_W'(3): w = {j.mac[31:0], 32'h0};
      FW_W'(4): w = {48'h0, j.mac[47:32]};
      FW_W'(29): w = {COOKIE_WORD, 32'h0};
      FW_W'(30): begin
        if (!j.request) begin
          w = {32'h0, 8'hff, MSG_DISCOVER, 16'h0135};
        end else begin
          w = {j.req_ip[23:0], 8'h04, 8'h32, MSG_REQUEST, 16'h0135};
        end
      end
      FW_W'(31): if (j.request) w = {56'h0, j.req_ip[31:24]};
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> design/dce_front.sv
module dce_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  dce_pkg::in_item_t item,
  input  logic [47:0]       mac_address,
  input  logic [7:0]        timeout_ticks,
  output dce_pkg::job_t     job
);
  import dce_pkg::*;

  logic [1:0]  client_state, client_state_next;
  logic [7:0]  wait_count, wait_count_next;
  logic [31:0] random_value, random_value_next;
  logic [31:0] own_identity, own_identity_next;
  logic [31:0] offered_ip, offered_ip_next;
  logic [31:0] bound_ip, bound_ip_next;
  logic [5:0]  rx_word_index;
  logic        reply_is_reply, reply_mac_ok, reply_is_dhcp;
  logic [31:0] reply_identifier, reply_your_ip;
  logic [7:0]  reply_type;
  logic        ri_n, rm_n, rd_n;
  logic [31:0] rid_n, ryi_n;
  logic [7:0]  rt_n;
  logic        have_reply, send, request;
  logic [31:0] hi;

  always_comb begin
    hi = item.rx_data[63:32];
    ri_n = reply_is_reply; rm_n = reply_mac_ok; rd_n = reply_is_dhcp;
    rid_n = reply_identifier; ryi_n = reply_your_ip; rt_n = reply_type;
    have_reply = 1'b0;
    if (item.command) begin
      case (rx_word_index)
        6'd0: begin
          ri_n = item.rx_data[7:0] == 8'd2; rid_n = hi; rm_n = 1'b1;
        end
        6'd2: ryi_n = item.rx_data[31:0];
        6'd3: rm_n = reply_mac_ok && (mac_address[31:0] == hi);
        6'd4: rm_n = reply_mac_ok && (mac_address[47:32] == item.rx_data[15:0]);
        6'd29: rd_n = hi == COOKIE_WORD;
        6'd30: if (item.rx_data[15:0] == 16'h0135) rt_n = item.rx_data[23:16];
        default: ;
      endcase
      have_reply = item.rx_last && ri_n && rm_n && rd_n;
    end
  end

  always_comb begin
    client_state_next = client_state; wait_count_next = wait_count;
    random_value_next = random_value; own_identity_next = own_identity;
    offered_ip_next = offered_ip; bound_ip_next = bound_ip;
    send = 1'b0; request = 1'b0;
    unique case (client_state)
      ST_INIT: if (item.enable) begin
        if (wait_count == 8'd0) begin
          own_identity_next = random_value; send = 1'b1;
          random_value_next = (random_value << 3) ^ random_value;
          wait_count_next = timeout_ticks; client_state_next = ST_SELECTING;
        end else begin
          wait_count_next = wait_count - 8'd1;
        end
      end
      ST_SELECTING, ST_REQUESTING: begin
        if (have_reply) begin
          if (rid_n == own_identity) begin
            if (client_state == ST_SELECTING && rt_n == MSG_OFFER) begin
              offered_ip_next = ryi_n; send = 1'b1; request = 1'b1;
              wait_count_next = timeout_ticks; client_state_next = ST_REQUESTING;
            end else if (client_state == ST_REQUESTING && rt_n == MSG_ACK) begin
              bound_ip_next = offered_ip; client_state_next = ST_BOUND;
            end else begin
              client_state_next = ST_INIT;
            end
          end
        end else if (wait_count == 8'd0) begin
          client_state_next = ST_INIT;
        end else begin
          wait_count_next = wait_count - 8'd1;
        end
      end
      default: if (!item.enable) client_state_next = ST_INIT;
    endcase
    random_value_next = random_value_next + 32'd1;
  end

  always_comb begin
    job.send = send;
    job.request = request;
    job.ident = own_identity_next;
    job.req_ip = ryi_n;
    job.mac = mac_address;
    job.bound_ip = bound_ip_next;
    job.is_bound = client_state_next == ST_BOUND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      client_state <= ST_INIT; wait_count <= WAIT_RESET; random_value <= RANDOM_SEED;
      own_identity <= '0; offered_ip <= '0; bound_ip <= '0; rx_word_index <= '0;
      reply_is_reply <= 1'b0; reply_mac_ok <= 1'b1; reply_is_dhcp <= 1'b0;
      reply_identifier <= '0; reply_your_ip <= '0; reply_type <= '0;
    end else if (in_fire) begin
      client_state <= client_state_next; wait_count <= wait_count_next;
      random_value <= random_value_next; own_identity <= own_identity_next;
      offered_ip <= offered_ip_next; bound_ip <= bound_ip_next;
      reply_is_reply <= ri_n; reply_mac_ok <= rm_n; reply_is_dhcp <= rd_n;
      reply_identifier <= rid_n; reply_your_ip <= ryi_n; reply_type <= rt_n;
      if (item.command) begin
        rx_word_index <= item.rx_last ? 6'd0 : rx_word_index + 6'd1;
      end
    end
  end

endmodule

>>> design/dce_queue.sv
module dce_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dce_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output dce_pkg::job_t head
);
  import dce_pkg::*;

  job_t       slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign full = count == 3'd4;
  assign not_empty = count != 3'd0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

>>> design/dce_back.sv
module dce_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_avail,
  input  dce_pkg::job_t      job,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output dce_pkg::out_item_t out_item
);
  import dce_pkg::*;

  logic [FW_W-1:0] word_idx;
  logic            fire, fin;

  assign fire = out_valid && !out_stall;
  assign out_valid = job_avail;
  assign fin = !job.send || (word_idx == FW_W'(FRAME_WORDS - 1));
  assign job_pop = fire && fin;

  always_comb begin
    out_item.tx_valid = job.send;
    out_item.tx_data = job.send ? frame_word(word_idx, job) : '0;
    out_item.tx_keep = !job.send ? 8'h00 : (fin ? 8'h0f : 8'hff);
    out_item.tx_last = job.send && fin;
    out_item.ip_address = job.bound_ip;
    out_item.is_bound = job.is_bound;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_idx <= '0;
    end else if (fire) begin
      word_idx <= fin ? '0 : word_idx + FW_W'(1);
    end
  end

endmodule

>>> design/dhcp_client_engine.sv
// DHCP client engine. Each input item is a timer tick or one 64-bit word of a
// received datagram; the front end parses the reply and steps the client state
// machine in the cycle the item is accepted, taking one item per cycle unless
// in_stall, raised only when the four-entry job queue is full. Each item
// yields one status item, or 38 frame items when a DISCOVER or REQUEST is
// issued; the back end plays them from that queue one per cycle unless stalled.
// Configuration writes are always ready and should be made while idle.
`include "dhcp_client_engine_defines.svh"
module dhcp_client_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dce_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dce_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data
);
  import dce_pkg::*;

  logic        in_fire, q_full, q_avail, q_pop;
  logic [47:0] mac_address;
  logic [7:0]  timeout_ticks;
  job_t        new_job, head_job;

  assign cfg_ready = 1'b1;
  assign in_stall = q_full;
  assign in_fire = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_address <= '0;
      timeout_ticks <= 8'hff;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAC: mac_address <= cfg_data[47:0];
        default: timeout_ticks <= cfg_data[7:0];
      endcase
    end
  end

  dce_front u_front (
    .clk, .rst, .in_fire, .item(in_data), .mac_address, .timeout_ticks, .job(new_job)
  );

  dce_queue u_queue (
    .clk, .rst, .push(in_fire), .push_job(new_job), .full(q_full),
    .pop(q_pop), .not_empty(q_avail), .head(head_job)
  );

  dce_back u_back (
    .clk, .rst, .job_avail(q_avail), .job(head_job), .job_pop(q_pop),
    .out_valid, .out_stall, .out_item(out_data)
  );

  // An item is never taken while the queue is full.
  `DCE_ASSERT_IMPL(a_no_overflow, clk, rst, q_full, !in_fire)
  // Output exists exactly when work is queued.
  `DCE_ASSERT_IMPL(a_out_when_job, clk, rst, out_valid, q_avail)
  // A finished frame word with last set retires its job.
  `DCE_ASSERT_IMPL(a_last_pops, clk, rst, out_valid && !out_stall && out_data.tx_last, q_pop)

endmodule
